FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, clocked, held off during reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/utf8cl_pkg.sv
// Types, constants and helper functions for the UTF-8 cluster length block.
`timescale 1ns / 1ps

package utf8cl_pkg;

	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 4;
	localparam int LEN_W   = 5;
	localparam int CODE_W  = 42;
	localparam int OUT_W   = 8;

	localparam logic [CNT_W-1:0]  CNT_MAX   = 4'd15;
	localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
	localparam logic [BYTE_W-1:0] LOW6_MASK = 8'h3F;

	localparam logic [15:0] CMB0_LO = 16'h0300;
	localparam logic [15:0] CMB0_HI = 16'h0370;
	localparam logic [15:0] CMB1_LO = 16'h1DC0;
	localparam logic [15:0] CMB1_HI = 16'h1E00;
	localparam logic [15:0] CMB2_LO = 16'h20D0;
	localparam logic [15:0] CMB2_HI = 16'h2100;
	localparam logic [15:0] CMB3_LO = 16'hFE20;
	localparam logic [15:0] CMB3_HI = 16'hFE30;

	typedef logic [CNT_W-1:0] cnt_t;

	// Count of ones from bit 7 down to the first zero (0..8).
	function automatic cnt_t lead_ones(input logic [BYTE_W-1:0] b);
		cnt_t n;
		logic run;
		n   = '0;
		run = 1'b1;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			run = run & b[i];
			if (run) n = n + cnt_t'(1);
		end
		return n;
	endfunction

	// Payload bits of a lead byte: (0x80 >> l) - 1, kept to 8 bits.
	function automatic logic [BYTE_W-1:0] lead_mask(input cnt_t l);
		logic [BYTE_W-1:0] top;
		top = CONT_TAG >> l;
		return top - 8'd1;
	endfunction

	function automatic logic is_cont(input logic [BYTE_W-1:0] b);
		return (b & CONT_MASK) == CONT_TAG;
	endfunction

	function automatic cnt_t sat_inc(input cnt_t c);
		return (c == CNT_MAX) ? CNT_MAX : c + cnt_t'(1);
	endfunction

	// Code point falls in one of the combining-mark blocks.
	function automatic logic combining(input logic [CODE_W-1:0] c);
		logic [15:0] lo;
		logic        hi_zero;
		lo      = c[15:0];
		hi_zero = (c[CODE_W-1:16] == '0);
		return hi_zero && ((lo >= CMB0_LO && lo < CMB0_HI) ||
			(lo >= CMB1_LO && lo < CMB1_HI) ||
			(lo >= CMB2_LO && lo < CMB2_HI) ||
			(lo >= CMB3_LO && lo < CMB3_HI));
	endfunction

endpackage

FILE: design/utf8_cluster_length.sv
// UTF-8 cluster length: byte length of the first code point plus a trailing combining mark.
// Pipeline: an accepted byte is held in the input stage register and decoded there;
//   its result beat is written into the output register when the stage advances.
// Throughput: one byte per cycle; the only stall is a result pending while the
//   previous result beat is still held by the output register.
// Reset: arst_n low clears the stage valid, output valid and decode state to idle.
`timescale 1ns / 1ps

module utf8_cluster_length import utf8cl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// input stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [BYTE_W-1:0] s_axis_tdata,  // [7:0] data_byte
	input  logic              s_axis_tuser,  // [0] start_query
	// result stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata   // [4:0] length, [5] error, [7:6] zero
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FIRST,
		PH_SECOND
	} phase_t;

	// Input stage: one registered byte beat.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;

	// Decode state.
	phase_t            phase_q;
	cnt_t              first_exp_q, first_seen_q;
	cnt_t              second_exp_q, second_seen_q;
	logic [CODE_W-1:0] code_q;

	// Result register.
	logic              out_valid_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_err_q;

	// Next-state values.
	phase_t            phase_d;
	cnt_t              first_exp_d, first_seen_d;
	cnt_t              second_exp_d, second_seen_d;
	logic [CODE_W-1:0] code_d;
	logic              emit;
	logic [LEN_W-1:0]  res_len;
	logic              res_err;

	logic              advance;
	cnt_t              lead;
	logic              cont;

	assign lead = lead_ones(byte_s1);
	assign cont = is_cont(byte_s1);

	always_comb begin
		phase_d       = phase_q;
		first_exp_d   = first_exp_q;
		first_seen_d  = first_seen_q;
		second_exp_d  = second_exp_q;
		second_seen_d = second_seen_q;
		code_d        = code_q;
		emit          = 1'b0;
		res_len       = '0;
		res_err       = 1'b0;

		if (start_s1) begin
			// A start abandons any query in flight.
			if (cont) begin
				emit    = 1'b1;
				res_err = 1'b1;
			end else if (byte_s1 == '0) begin
				emit = 1'b1;  // empty string
			end else begin
				first_exp_d   = (lead == '0) ? cnt_t'(1) : lead;
				first_seen_d  = cnt_t'(1);
				second_exp_d  = '0;
				second_seen_d = '0;
				code_d        = '0;
				phase_d       = PH_FIRST;
			end
		end else begin
			case (phase_q)
				PH_FIRST: begin
					if (cont) begin
						first_seen_d = sat_inc(first_seen_q);
					end else if (first_seen_q != first_exp_q) begin
						emit    = 1'b1;
						res_err = 1'b1;
					end else if (lead == '0) begin
						// single-byte follower, terminator included
						emit    = 1'b1;
						res_len = {1'b0, first_exp_q};
					end else begin
						second_exp_d  = lead;
						second_seen_d = cnt_t'(1);
						code_d        = {{(CODE_W-BYTE_W){1'b0}}, byte_s1 & lead_mask(lead)};
						phase_d       = PH_SECOND;
					end
				end
				PH_SECOND: begin
					if (cont) begin
						second_seen_d = sat_inc(second_seen_q);
						code_d        = {code_q[CODE_W-7:0], byte_s1[5:0]};
					end else if (second_seen_q != second_exp_q) begin
						emit    = 1'b1;
						res_err = 1'b1;
					end else if (combining(code_q)) begin
						emit    = 1'b1;
						res_len = {1'b0, first_exp_q} + {1'b0, second_exp_q};
					end else begin
						emit    = 1'b1;
						res_len = {1'b0, first_exp_q};
					end
				end
				default: begin
					// idle bytes without a start are dropped
				end
			endcase
		end

		if (emit) phase_d = PH_IDLE;
	end

	// The stage moves unless it holds a result and the output is still full.
	assign advance       = valid_s1 && !(emit && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			byte_s1       <= '0;
			start_s1      <= 1'b0;
			phase_q       <= PH_IDLE;
			first_exp_q   <= '0;
			first_seen_q  <= '0;
			second_exp_q  <= '0;
			second_seen_q <= '0;
			code_q        <= '0;
			out_valid_q   <= 1'b0;
			out_len_q     <= '0;
			out_err_q     <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
				byte_s1  <= s_axis_tdata;
				start_s1 <= s_axis_tuser;
			end
			if (advance) begin
				phase_q       <= phase_d;
				first_exp_q   <= first_exp_d;
				first_seen_q  <= first_seen_d;
				second_exp_q  <= second_exp_d;
				second_seen_q <= second_seen_d;
				code_q        <= code_d;
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
				out_len_q   <= res_len;
				out_err_q   <= res_err;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W-LEN_W-1){1'b0}}, out_err_q, out_len_q};

endmodule

FILE: design/utf8cl_checker.sv
// Port-level assertions for the UTF-8 cluster length block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8cl_checker import utf8cl_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [OUT_W-1:0]  m_axis_tdata
);

	// An empty output register never holds back the input side.
	`ASSERT_CLK(a_in_ready, clk, arst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled")
	`ASSERT_CLK(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "beat dropped")
	`ASSERT_CLK(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "beat changed")
	`ASSERT_NEVER(a_err_len, clk, arst_n, m_axis_tvalid && m_axis_tdata[5] && (m_axis_tdata[4:0] != 5'd0), "error length")
	`ASSERT_NEVER(a_len_range, clk, arst_n, m_axis_tvalid && ((m_axis_tdata[4:0] > 5'd16) || (m_axis_tdata[7:6] != 2'd0)), "bad length")

endmodule

bind utf8_cluster_length utf8cl_checker u_utf8cl_checker (.*);

FILE: test/utf8_cluster_length_tb.sv
// Self-checking testbench for utf8_cluster_length: directed and random byte streams.
`timescale 1ns / 1ps

module utf8_cluster_length_tb import utf8cl_pkg::*; ;

	// Predicts the cluster length of every query and holds the answers not yet seen.
	class cluster_scoreboard;
		typedef enum logic [2:0] {WAIT_START, IN_FIRST, IN_SECOND} walk_t;
		typedef struct packed {
			logic [LEN_W-1:0] length;
			logic             error;
		} answer_t;

		walk_t             walk;
		cnt_t              first_len, first_got, mark_len, mark_got;
		logic [CODE_W-1:0] mark_code;
		answer_t           answers[$];

		function new();
			walk      = WAIT_START;
			first_len = '0;
			first_got = '0;
			mark_len  = '0;
			mark_got  = '0;
			mark_code = '0;
		endfunction

		static function cnt_t top_ones(input logic [7:0] b);
			cnt_t n;
			n = '0;
			while (n < 8 && b[7 - n]) n = n + 1'b1;
			return n;
		endfunction

		static function cnt_t bump(input cnt_t c);
			return (c == 4'd15) ? c : c + 1'b1;
		endfunction

		function void close(input logic [LEN_W-1:0] len, input logic err);
			answer_t a;
			a.length = err ? '0 : len;
			a.error  = err;
			answers.push_back(a);
			walk = WAIT_START;
		endfunction

		// Returns 1 when the byte is taken into a query, 0 when the block ignores it.
		function bit note_byte(input logic [7:0] b, input logic st);
			cnt_t       ones;
			logic [7:0] keep;
			ones = top_ones(b);
			if (st) begin
				if (ones == 1) close('0, 1'b1);
				else if (b == 8'h00) close('0, 1'b0);
				else begin
					first_len = (ones == 0) ? cnt_t'(1) : ones;
					first_got = 4'd1;
					mark_len  = '0;
					mark_got  = '0;
					mark_code = '0;
					walk      = IN_FIRST;
				end
				return 1'b1;
			end
			case (walk)
				IN_FIRST: begin
					if (b[7:6] == 2'b10) first_got = bump(first_got);
					else if (first_got != first_len) close('0, 1'b1);
					else if (ones == 0) close(LEN_W'(first_len), 1'b0);
					else begin
						mark_len  = ones;
						mark_got  = 4'd1;
						keep      = (8'h80 >> ones) - 8'd1;
						mark_code = CODE_W'(b & keep);
						walk      = IN_SECOND;
					end
					return 1'b1;
				end
				IN_SECOND: begin
					if (b[7:6] == 2'b10) begin
						mark_got  = bump(mark_got);
						mark_code = {mark_code[CODE_W-7:0], b[5:0]};
					end else if (mark_got != mark_len) close('0, 1'b1);
					else if ((mark_code >= CMB0_LO && mark_code < CMB0_HI) ||
						(mark_code >= CMB1_LO && mark_code < CMB1_HI) ||
						(mark_code >= CMB2_LO && mark_code < CMB2_HI) ||
						(mark_code >= CMB3_LO && mark_code < CMB3_HI))
						close(LEN_W'(first_len) + LEN_W'(mark_len), 1'b0);
					else close(LEN_W'(first_len), 1'b0);
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function bit check_result(input logic [OUT_W-1:0] beat, output string why);
			answer_t want;
			why = "";
			if (answers.size() == 0) begin
				why = $sformatf(" result beat %02h with no query outstanding", beat);
				return 1'b0;
			end
			want = answers.pop_front();
			if (beat[4:0] !== want.length)
				why = {why, $sformatf(" length got %0d want %0d", beat[4:0], want.length)};
			if (beat[5] !== want.error)
				why = {why, $sformatf(" error got %b want %b", beat[5], want.error)};
			if (beat[7:6] !== 2'b00)
				why = {why, $sformatf(" pad bits got %b", beat[7:6])};
			return why == "";
		endfunction

		function int pending();
			return answers.size();
		endfunction
	endclass

	localparam int BYTE_TARGET = 1450;
	localparam int IDLE_PCT    = 18;
	localparam int STALL_LIMIT = 2000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [BYTE_W-1:0] s_axis_tdata = '0;
	logic              s_axis_tuser = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	cluster_scoreboard sb;
	logic [8:0]        beat_q[$];   // {start_query, data_byte}
	logic [8:0]        draft_q[$];
	int                live_bytes = 0;
	int                fail_cnt = 0;
	int                quiet_cycles = 0;
	bit                no_idle = 1'b0;

	utf8_cluster_length uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),   // [7:0] data_byte
		.s_axis_tuser (s_axis_tuser),   // [0] start_query
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)    // [4:0] length, [5] error, [7:6] zero
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task report_mismatch(input string why);
		fail_cnt++;
		$display("mismatch at %0t ns:%s", $time, why);
	endtask

	// One input beat; returns at the edge where it was taken.
	task automatic drive_beat(input logic [7:0] b, input logic st);
		bit took;
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= st;
		do begin
			@(negedge clk);
			took = s_axis_tvalid && s_axis_tready;
			@(posedge clk);
		end while (!took);
		// every accepted beat counts toward the target, ignored ones included
		void'(sb.note_byte(b, st));
		live_bytes++;
		no_idle = (live_bytes >= 500 && live_bytes < 800);
	endtask

	// Encodes value as an n-byte sequence; n = 8 gives the all-ones lead.
	task automatic add_code(input logic [63:0] value, input int n, input logic st);
		logic [7:0] prefix, keep, lead;
		if (n == 1) lead = {1'b0, value[6:0]};
		else begin
			prefix = ~(8'hFF >> n);
			keep   = (8'h80 >> n) - 8'd1;
			lead   = prefix | (8'(value >> (6 * (n - 1))) & keep);
		end
		draft_q.push_back({st, lead});
		for (int k = n - 2; k >= 0; k--)
			draft_q.push_back({1'b0, 2'b10, 6'(value >> (6 * k))});
	endtask

	// Mostly well-formed queries with random content, plus noise and broken ones.
	task automatic make_query();
		int          r, c, n1, n2, nmin, idx;
		logic [15:0] lo, hi;
		logic [63:0] v;
		logic [7:0]  b;
		draft_q.delete();
		r = $urandom_range(0, 99);
		if (r < 4) draft_q.push_back(9'h100);
		else if (r < 8) draft_q.push_back({1'b1, 2'b10, 6'($urandom)});
		else if (r < 14) begin
			repeat ($urandom_range(1, 6))
				draft_q.push_back({1'($urandom_range(0, 99) < 30), 8'($urandom)});
		end else begin
			n1 = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 8);
			add_code({$urandom, $urandom}, n1, 1'b1);
			// runs of stray continuation bytes, some long enough to saturate the counter
			if ($urandom_range(0, 99) < 8)
				repeat ($urandom_range(1, 16)) draft_q.push_back({1'b0, 2'b10, 6'($urandom)});
			c = $urandom_range(0, 99);
			if (c < 25) draft_q.push_back({1'b0, 1'b0, 7'($urandom)});
			else begin
				idx = $urandom_range(0, 3);
				case (idx)
					0: begin lo = CMB0_LO; hi = CMB0_HI; end
					1: begin lo = CMB1_LO; hi = CMB1_HI; end
					2: begin lo = CMB2_LO; hi = CMB2_HI; end
					default: begin lo = CMB3_LO; hi = CMB3_HI; end
				endcase
				if (c < 65) v = 64'($urandom_range(lo, hi - 1));
				else if (c < 80) begin
					case ($urandom_range(0, 3))
						0: v = 64'(lo - 16'd1);
						1: v = 64'(lo);
						2: v = 64'(hi - 16'd1);
						default: v = 64'(hi);
					endcase
				end else v = {$urandom, $urandom};
				nmin = (v < 64'h800) ? 2 : 3;
				if (c >= 80) n2 = $urandom_range(2, 8);
				else if ($urandom_range(0, 9) < 7) n2 = nmin;
				else n2 = $urandom_range(nmin + 1, 8);   // overlong forms
				add_code(v, n2, 1'b0);
				b = 8'($urandom);
				if (b[7:6] == 2'b10) b[6] = 1'b1;
				draft_q.push_back({1'b0, b});
			end
			if ($urandom_range(0, 99) < 4 && draft_q.size() > 1)
				draft_q.delete($urandom_range(1, draft_q.size() - 1));
			// cut short: the next start abandons this query
			if ($urandom_range(0, 99) < 5) begin
				idx = $urandom_range(1, draft_q.size());
				while (draft_q.size() > idx) void'(draft_q.pop_back());
			end
		end
		if ($urandom_range(0, 99) < 30)
			repeat ($urandom_range(1, 3)) draft_q.push_back({1'b0, 8'($urandom)});
		beat_q = {beat_q, draft_q};
	endtask

	// Result sink with random stalls.
	always @(posedge clk) begin
		m_axis_tready <= arst_n && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
	end

	// Checks results and watches for a stuck pipe; both sampled mid-cycle.
	always @(negedge clk) begin
		string why;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready && !sb.check_result(m_axis_tdata, why))
				report_mismatch(why);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [8:0] bt;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		beat_q = '{
			9'h100,                                  // empty string
			9'h180,                                  // lone continuation lead
			9'h055,                                  // byte while idle, ignored
			9'h141, 9'h000,                          // ascii then terminator
			9'h165, 9'h0CC, 9'h081, 9'h000,          // e + U+0301 combining mark
			9'h1C3, 9'h0FF,                          // two-byte lead cut short
			9'h1FF, 9'h180,                          // restart mid-query
			9'h1E2, 9'h082, 9'h0AC, 9'h0FF, 9'h0BF, 9'h041,  // all-ones second lead
			9'h1F0, 9'h080, 9'h080, 9'h080, 9'h080, 9'h000   // too many continuations
		};
		while (beat_q.size() != 0 || live_bytes < BYTE_TARGET) begin
			if (beat_q.size() == 0) make_query();
			bt = beat_q.pop_front();
			drive_beat(bt[7:0], bt[8]);
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_cnt == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
